/* design/pos_pkg.sv */
// Package: payload types and CORDIC constants for the polyline offset stream.
package pos_pkg;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic               last_point;
  } pos_in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic               out_last;
  } pos_out_t;

  // Command from front to back.
  typedef struct packed {
    logic               pass;      // emit as is
    logic               is_last;
    logic               do_mean;   // held vertex uses mean of prev and new normal
    logic               emit_held;
    logic               emit_new;
    logic signed [15:0] hx;
    logic signed [15:0] hy;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [10:0] distance;
  } pos_cmd_t;

  localparam int CordicSteps = 30;
  localparam logic [63:0] CordicStart = 64'd652032874;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;  5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4;  5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;  5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F;  5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005; 5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

/* design/polyline_offset_stream_unit.sv */
// Top level: polyline parallel offset over front, queue and back.
// A vertex that needs offsetting holds the shared CORDIC unit for a 30-step atan2,
// then, for each of its one or two results, a setup step plus 30 cos/sin steps,
// multiply and output; a zero-length segment skips atan2. Pass-through and
// single-vertex items go straight to the output stage, and the opening vertex of
// a path is only held in the front. A two-entry command queue lets the front run
// ahead; full is high while it is full, and the back end stalls in its output
// stage while a result waits for pop.
module polyline_offset_stream_unit #(
  parameter int ANGLE_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  pos_pkg::pos_in_t   in_item,
  output logic               empty,
  input  logic               pop,
  output pos_pkg::pos_out_t  out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic signed [10:0] cfg_data
);
  import pos_pkg::*;

  logic signed [10:0] shift_distance;
  logic f_valid, f_ready, b_valid, b_ready;
  pos_cmd_t f_cmd, b_cmd;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) shift_distance <= '0;
    else if (cfg_valid) shift_distance <= cfg_data;
  end

  pos_front u_front (.clk, .rst, .push, .full, .in_item, .distance(shift_distance),
    .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd));
  pos_queue u_queue (.clk, .rst, .in_valid(f_valid), .in_ready(f_ready),
    .in_cmd(f_cmd), .out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd));
  pos_back #(.ANGLE_BITS(ANGLE_BITS)) u_back (.clk, .rst, .cmd_valid(b_valid),
    .cmd_ready(b_ready), .cmd(b_cmd), .empty, .pop, .res(out_item));
endmodule

/* design/pos_front.sv */
// Front end: takes vertices, tracks path phase, issues commands to the queue.
module pos_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  pos_pkg::pos_in_t in_item,
  input  logic signed [10:0] distance,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output pos_pkg::pos_cmd_t cmd
);
  import pos_pkg::*;

  logic [1:0] phase;
  logic signed [15:0] held_x, held_y;
  logic acc;
  logic need;

  // opening vertex of a path is only held, nothing goes to the back end, unless it is last or distance is 0
  assign need = (phase != 2'd0) || in_item.last_point || (distance == '0);
  assign full = !cmd_ready;
  assign cmd_valid = push && need;
  assign acc = push && cmd_ready;

  always_comb begin
    cmd.pass      = (distance == '0) || (phase == 2'd0);
    cmd.is_last   = in_item.last_point;
    cmd.do_mean   = (phase == 2'd2);
    cmd.emit_held = (phase != 2'd0);
    cmd.emit_new  = in_item.last_point || (distance == '0);
    cmd.hx        = held_x;
    cmd.hy        = held_y;
    cmd.px        = in_item.point_x;
    cmd.py        = in_item.point_y;
    cmd.distance  = distance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
    end else if (acc) begin
      if (distance == '0 || in_item.last_point) begin
        phase <= 2'd0;
      end else begin
        phase <= (phase == 2'd0) ? 2'd1 : 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      held_x <= in_item.point_x;
      held_y <= in_item.point_y;
    end
  end
endmodule

/* design/pos_queue.sv */
// Two-entry command queue between front and back.
module pos_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pos_pkg::pos_cmd_t in_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output pos_pkg::pos_cmd_t out_cmd
);
  import pos_pkg::*;

  pos_cmd_t slot [2];
  logic wp, rp;
  logic [1:0] count;

  assign in_ready = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_cmd = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= !wp;
      if (out_valid && out_ready) rp <= !rp;
      count <= count + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) slot[wp] <= in_cmd;
  end
endmodule

/* design/pos_back.sv */
// Back end: CORDIC atan2 and cos/sin, offset and output register.
module pos_back #(
  parameter int ANGLE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  pos_pkg::pos_cmd_t cmd,
  output logic              empty,
  input  logic              pop,
  output pos_pkg::pos_out_t res
);
  import pos_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_VEC  = 7'b0000010,
    S_ROT  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_OUT  = 7'b0010000,
    S_WAIT = 7'b0100000,
    S_NEXT = 7'b1000000
  } state_t;

  state_t state;
  pos_cmd_t c;
  logic signed [63:0] x, y, zs;
  logic [31:0] z;
  logic [4:0] step;
  logic [ANGLE_BITS-1:0] prev_n, n_ang, ang;
  logic second;  // working on the new vertex
  logic flip;
  logic signed [15:0] cq, sq;
  logic signed [31:0] mx, my;
  logic out_full, out_full_next;
  logic emit;
  logic signed [63:0] xs, ys;
  logic [31:0] at;
  logic [ANGLE_BITS-1:0] d, half, nz, mean;
  logic [31:0] u;
  logic signed [16:0] dx0, dy0;

  assign xs = x >>> step;
  assign ys = y >>> step;
  assign at = atan_entry(step);
  assign cmd_ready = (state == S_IDLE);
  assign empty = !out_full;
  assign dx0 = 17'(cmd.px) - 17'(cmd.hx);
  assign dy0 = 17'(cmd.py) - 17'(cmd.hy);
  assign emit = (state == S_OUT) && (!out_full || pop);

  function automatic logic signed [15:0] rq15(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v >= 0) r = (v + 64'sd16384) >>> 15;
    else r = -((-v + 64'sd16384) >>> 15);
    if (r > 64'sd32767) return 16'sd32767;
    if (r < -64'sd32768) return -16'sd32768;
    return r[15:0];
  endfunction

  function automatic logic signed [15:0] sat(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'sd32767;
    if (v < -18'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

  assign cq = rq15(flip ? -x : x);
  assign sq = rq15(flip ? -y : y);

  always_comb begin
    out_full_next = out_full;
    if (pop && out_full) out_full_next = 1'b0;
    if (emit) out_full_next = 1'b1;
  end

  always_comb begin
    nz = ANGLE_BITS'((z + (32'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS))
         + (ANGLE_BITS'(1) << (ANGLE_BITS - 2));
    d = nz - prev_n;
    half = {d[ANGLE_BITS-1], d[ANGLE_BITS-1:1]};
    mean = prev_n + half;
    u = 32'(ang) << (32 - ANGLE_BITS);
  end

  logic signed [17:0] ox, oy;
  logic signed [15:0] bx, by;
  logic signed [31:0] rmx, rmy;
  always_comb begin
    rmx = (mx >= 0) ? ((mx + 32'sd16384) >>> 15) : -((-mx + 32'sd16384) >>> 15);
    rmy = (my >= 0) ? ((my + 32'sd16384) >>> 15) : -((-my + 32'sd16384) >>> 15);
    bx = second ? c.px : c.hx;
    by = second ? c.py : c.hy;
    ox = 18'(bx) + 18'(rmx);
    oy = 18'(by) + 18'(rmy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_full <= 1'b0;
      prev_n <= '0;
    end else begin
      out_full <= out_full_next;
      unique case (state)
        S_IDLE: if (cmd_valid) begin
          c <= cmd;
          second <= !cmd.emit_held;
          if (cmd.pass) begin
            state <= S_OUT;
          end else if (dx0 == '0 && dy0 == '0) begin
            // zero-length segment: direction is angle 0
            z <= 32'd0;
            state <= S_NEXT;
          end else if (dx0 < 0) begin
            x <= -(64'(dx0) * 64'sd4096);
            y <= -(64'(dy0) * 64'sd4096);
            z <= 32'h80000000;
            step <= 5'd0;
            state <= S_VEC;
          end else begin
            x <= 64'(dx0) * 64'sd4096;
            y <= 64'(dy0) * 64'sd4096;
            z <= 32'd0;
            step <= 5'd0;
            state <= S_VEC;
          end
        end
        S_VEC: begin
          if (y > 0) begin
            x <= x + ys; y <= y - xs; z <= z + at;
          end else begin
            x <= x - ys; y <= y + xs; z <= z - at;
          end
          if (step == 5'(CordicSteps - 1)) state <= S_NEXT;
          step <= step + 5'd1;
        end
        S_NEXT: begin
          n_ang <= nz;
          ang <= c.do_mean ? mean : nz;
          if (!c.is_last) prev_n <= nz;
          state <= S_ROT;
          x <= 64'(CordicStart);
          y <= '0;
          step <= 5'd31;
        end
        S_ROT: begin
          if (step == 5'd31) begin
            if (u >= 32'h40000000 && u < 32'hC0000000) begin
              zs <= 64'(signed'(u - 32'h80000000));
              flip <= 1'b1;
            end else begin
              zs <= 64'(signed'(u));
              flip <= 1'b0;
            end
            step <= 5'd0;
          end else begin
            if (zs >= 0) begin
              x <= x - ys; y <= y + xs; zs <= zs - 64'(at);
            end else begin
              x <= x + ys; y <= y - xs; zs <= zs + 64'(at);
            end
            if (step == 5'(CordicSteps - 1)) state <= S_MUL;
            step <= step + 5'd1;
          end
        end
        S_MUL: begin
          mx <= 32'(c.distance) * 32'(cq);
          my <= 32'(c.distance) * 32'(sq);
          state <= S_OUT;
        end
        S_OUT: if (emit) begin
          if (c.pass) begin
            res.out_x <= bx; res.out_y <= by;
          end else begin
            res.out_x <= sat(ox); res.out_y <= sat(oy);
          end
          res.out_last <= second && c.is_last;
          if (!second && c.emit_new) begin
            second <= 1'b1;
            if (!c.pass) begin
              ang <= n_ang;
              x <= 64'(CordicStart); y <= '0; step <= 5'd31;
              state <= S_ROT;
            end
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_full && !pop |=> out_full) else $error("result dropped");
  a_take: assert property (@(posedge clk) disable iff (rst)
    cmd_ready && cmd_valid |=> !cmd_ready) else $error("double take");
  a_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state)) else $error("state code");
`endif
endmodule
